// ----- rtl/rmcl_pkg.sv -----
// ----------------------------------------------------------------------------
// rmcl_pkg
// Shared types and constants for the RTP MIDI command list parser.
// ----------------------------------------------------------------------------
package rmcl_pkg;

  localparam int unsigned TimeW = 32;

  localparam logic [7:0]       StatusSysexStart = 8'hF0;
  localparam logic [7:0]       StatusSysexEnd   = 8'hF7;
  localparam logic [7:0]       StatusMeta       = 8'hFF;
  localparam logic [TimeW-1:0] VarlenShiftMax   = 32'h01FF_FFFF;
  localparam logic [TimeW-1:0] MetaLenBase      = 32'h7FFF_FFFE;

  typedef enum logic [6:0] {
    PH_SKIP      = 7'b000_0001,
    PH_DELTA     = 7'b000_0010,
    PH_STATUS    = 7'b000_0100,
    PH_FIXED     = 7'b000_1000,
    PH_SYSEX     = 7'b001_0000,
    PH_META_LEN  = 7'b010_0000,
    PH_META_BODY = 7'b100_0000
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BAD_STATUS = 3'd1,
    ERR_VARLEN     = 3'd2,
    ERR_TRUNCATED  = 3'd3,
    ERR_META_LONG  = 3'd4
  } err_code_t;

  // Registered input byte; base_time already holds timestamp + playout delay.
  typedef struct packed {
    logic [7:0]       data_byte;
    logic             first_of_list;
    logic             last_of_list;
    logic             z_flag;
    logic [TimeW-1:0] base_time;
  } item_t;

  typedef struct packed {
    logic [7:0]       midi_byte;
    logic [TimeW-1:0] event_time;
    logic             command_start;
    logic             command_end;
    logic             trim_byte;
    err_code_t        error_code;
  } result_t;

endpackage

// ----- rtl/rmcl_in_reg.sv -----
// ----------------------------------------------------------------------------
// rmcl_in_reg
// Input register with playout delay register and packet base time adder.
// ----------------------------------------------------------------------------
module rmcl_in_reg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [31:0]               cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                data_byte,
  input  logic                      first_of_list,
  input  logic                      last_of_list,
  input  logic [31:0]               packet_time,
  input  logic                      z_flag,
  input  logic                      advance,
  output logic                      item_valid,
  output rmcl_pkg::item_t           item
);
  import rmcl_pkg::*;

  logic [TimeW-1:0] playout_delay;

  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      playout_delay <= '0;
    end else if (cfg_wr_en) begin
      playout_delay <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.data_byte     <= data_byte;
      item.first_of_list <= first_of_list;
      item.last_of_list  <= last_of_list;
      item.z_flag        <= z_flag;
      item.base_time     <= packet_time + playout_delay;
    end
  end

endmodule

// ----- rtl/rmcl_core.sv -----
// ----------------------------------------------------------------------------
// rmcl_core
// Parse state, per-byte decode and result register.
// ----------------------------------------------------------------------------
module rmcl_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  input  rmcl_pkg::item_t           item,
  output logic                      advance,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rmcl_pkg::result_t         result
);
  import rmcl_pkg::*;

  phase_t           phase, phase_next;
  logic [TimeW-1:0] bytes_left, bytes_left_next;
  logic [TimeW-1:0] varlen_accum, varlen_accum_next;
  logic [2:0]       varlen_count, varlen_count_next;
  logic [TimeW-1:0] running_time, running_time_next;

  phase_t           ph_cur;
  logic [TimeW-1:0] left_cur, acc_cur, rt_cur;
  logic [2:0]       cnt_cur, cnt_inc;
  logic [TimeW-1:0] acc_shift, left_dec, meta_limit;
  logic             vl_ovf, vl_done;
  logic             have, st, en, tr, emit;
  err_code_t        err;
  logic [7:0]       b;

  assign advance = item_valid && (!out_valid || out_ready);
  assign b       = item.data_byte;

  always_comb begin
    ph_cur     = item.first_of_list ? (item.z_flag ? PH_DELTA : PH_STATUS) : phase;
    left_cur   = item.first_of_list ? '0 : bytes_left;
    acc_cur    = item.first_of_list ? '0 : varlen_accum;
    cnt_cur    = item.first_of_list ? '0 : varlen_count;
    rt_cur     = item.first_of_list ? item.base_time : running_time;

    vl_ovf     = acc_cur > VarlenShiftMax;
    vl_done    = !b[7];
    acc_shift  = {acc_cur[TimeW-8:0], b[6:0]};
    cnt_inc    = (cnt_cur == 3'd7) ? cnt_cur : cnt_cur + 3'd1;
    meta_limit = MetaLenBase - TimeW'(cnt_inc);
    left_dec   = (left_cur != '0) ? left_cur - TimeW'(1) : left_cur;

    phase_next        = ph_cur;
    bytes_left_next   = left_cur;
    varlen_accum_next = acc_cur;
    varlen_count_next = cnt_cur;
    running_time_next = rt_cur;
    have = 1'b0;
    st   = 1'b0;
    en   = 1'b0;
    tr   = 1'b0;
    err  = ERR_NONE;

    unique case (ph_cur)
      PH_DELTA: begin
        if (vl_ovf) begin
          err = ERR_VARLEN;
        end else begin
          varlen_accum_next = acc_shift;
          varlen_count_next = cnt_inc;
          if (vl_done) begin
            running_time_next = rt_cur + acc_shift;
            varlen_accum_next = '0;
            varlen_count_next = '0;
            phase_next        = PH_STATUS;
          end
        end
      end
      PH_STATUS: begin
        have = 1'b1;
        st   = 1'b1;
        unique case (b) inside
          [8'h80:8'hBF], [8'hE0:8'hEF]: begin
            bytes_left_next = TimeW'(2);
            phase_next      = PH_FIXED;
          end
          [8'hC0:8'hDF]: begin
            bytes_left_next = TimeW'(1);
            phase_next      = PH_FIXED;
          end
          StatusSysexStart, StatusSysexEnd: begin
            phase_next = PH_SYSEX;
          end
          StatusMeta: begin
            varlen_accum_next = '0;
            varlen_count_next = '0;
            phase_next        = PH_META_LEN;
          end
          default: begin
            err = ERR_BAD_STATUS;
          end
        endcase
      end
      PH_FIXED, PH_META_BODY: begin
        have            = 1'b1;
        bytes_left_next = left_dec;
        if (left_dec == '0) begin
          en         = 1'b1;
          phase_next = PH_DELTA;
        end
      end
      PH_SYSEX: begin
        have = 1'b1;
        if (b == StatusSysexStart || b == StatusSysexEnd) begin
          en         = 1'b1;
          tr         = (b == StatusSysexStart);
          phase_next = PH_DELTA;
        end
      end
      PH_META_LEN: begin
        have = 1'b1;
        if (vl_ovf) begin
          err = ERR_VARLEN;
        end else begin
          varlen_accum_next = acc_shift;
          varlen_count_next = cnt_inc;
          if (vl_done) begin
            if (acc_shift > meta_limit) begin
              err = ERR_META_LONG;
            end else if (acc_shift == '0) begin
              en         = 1'b1;
              phase_next = PH_DELTA;
            end else begin
              bytes_left_next = acc_shift;
              phase_next      = PH_META_BODY;
            end
            varlen_accum_next = '0;
            varlen_count_next = '0;
          end
        end
      end
      default: begin
        phase_next = PH_SKIP;
      end
    endcase

    if (ph_cur != PH_SKIP && err == ERR_NONE && item.last_of_list && !(have && en)) begin
      err = ERR_TRUNCATED;
    end
    if (err != ERR_NONE || (ph_cur != PH_SKIP && item.last_of_list)) begin
      phase_next = PH_SKIP;
    end
    emit = have || (err != ERR_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SKIP;
      bytes_left   <= '0;
      varlen_accum <= '0;
      varlen_count <= '0;
      running_time <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      bytes_left   <= bytes_left_next;
      varlen_accum <= varlen_accum_next;
      varlen_count <= varlen_count_next;
      running_time <= running_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.midi_byte     <= b;
      result.event_time    <= running_time_next;
      result.command_start <= st && (err == ERR_NONE);
      result.command_end   <= en && (err == ERR_NONE);
      result.trim_byte     <= tr && (err == ERR_NONE);
      result.error_code    <= err;
    end
  end

  // error transactions carry no command framing
  a_err_no_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.error_code != ERR_NONE
      |-> !result.command_start && !result.command_end && !result.trim_byte)
    else $error("error result with command flags");

  a_trim_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.trim_byte
      |-> result.command_end && result.midi_byte == StatusSysexStart)
    else $error("trim on a byte that is not a closing F0");

  a_start_is_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.command_start |-> result.midi_byte[7])
    else $error("command start on a data byte");

  a_skip_after_error: assert property (@(posedge clk) disable iff (rst)
    advance && err != ERR_NONE |=> phase == PH_SKIP)
    else $error("parser not skipping after error");

endmodule

// ----- rtl/rtp_midi_command_list_parser.sv -----
// Path: a byte accepted into the input register is decoded combinationally and its
// result is registered in the result register, from which it is ready to be taken.
// Throughput: one byte per cycle while the output is not stalled; the input register and
// the result register stay full under output stall and resume without a bubble.
// Timing: the per-byte path is a 32-bit add (delta into running time), 32-bit subtracts and compares.
// Reset: synchronous; clears playout delay, parse state (skip until the next
// first byte) and both valid flags.
// ----------------------------------------------------------------------------
// rtp_midi_command_list_parser
// RTP MIDI command list parser: delta times, command sizing, timed byte output.
// ----------------------------------------------------------------------------
module rtp_midi_command_list_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        first_of_list,
  input  logic        last_of_list,
  input  logic [31:0] packet_time,
  input  logic        z_flag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  midi_byte,
  output logic [31:0] event_time,
  output logic        command_start,
  output logic        command_end,
  output logic        trim_byte,
  output logic [2:0]  error_code
);
  import rmcl_pkg::*;

  logic    item_valid;
  logic    advance;
  item_t   item;
  result_t result;

  rmcl_in_reg u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .first_of_list (first_of_list),
    .last_of_list  (last_of_list),
    .packet_time   (packet_time),
    .z_flag        (z_flag),
    .advance       (advance),
    .item_valid    (item_valid),
    .item          (item)
  );

  rmcl_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

  assign midi_byte     = result.midi_byte;
  assign event_time    = result.event_time;
  assign command_start = result.command_start;
  assign command_end   = result.command_end;
  assign trim_byte     = result.trim_byte;
  assign error_code    = result.error_code;

endmodule

// ----- tb/sv/rtp_midi_parse_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtp_midi_parse_checker
// Watches the configuration port and both byte channels of the RTP MIDI
// command list parser. It tracks the parse state of the byte stream to
// predict each timed output byte (or error report), queues the predictions
// and compares every output transaction field by field in order.
// ----------------------------------------------------------------------------
module rtp_midi_parse_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        first_of_list,
  input  logic        last_of_list,
  input  logic [31:0] packet_time,
  input  logic        z_flag,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  midi_byte,
  input  logic [31:0] event_time,
  input  logic        command_start,
  input  logic        command_end,
  input  logic        trim_byte,
  input  logic [2:0]  error_code,
  output int          mismatches,
  output int          pending,
  output int          timed_bytes,
  output int          error_reports
);
  import rmcl_pkg::*;

  phase_t      ph;
  logic [31:0] delay;
  logic [31:0] remain;
  logic [31:0] acc;
  logic [2:0]  acc_len;
  logic [31:0] cur_time;
  result_t     expected_bytes[$];

  // -1: overflow, 1: value complete, 0: more bytes follow
  function automatic int take_varlen(input logic [7:0] b);
    if (acc > VarlenShiftMax) return -1;
    acc = (acc << 7) | 32'(b[6:0]);
    if (acc_len < 3'd7) acc_len++;
    return b[7] ? 0 : 1;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic is_first,
                                     input logic is_last, input logic [31:0] ptime,
                                     input logic zf, output bit emit, output result_t r);
    bit        has_byte;
    bit        ends;
    int        vl;
    err_code_t err;
    emit = 1'b0;
    has_byte = 1'b0;
    ends = 1'b0;
    err = ERR_NONE;
    r = '0;
    if (is_first) begin
      cur_time = ptime + delay;
      acc = '0;
      acc_len = '0;
      remain = '0;
      ph = zf ? PH_DELTA : PH_STATUS;
    end
    if (ph == PH_SKIP) return;
    r.midi_byte = b;
    case (ph)
      PH_DELTA: begin
        vl = take_varlen(b);
        if (vl < 0) begin
          err = ERR_VARLEN;
        end else if (vl > 0) begin
          cur_time += acc;
          acc = '0;
          acc_len = '0;
          ph = PH_STATUS;
        end
      end
      PH_STATUS: begin
        has_byte = 1'b1;
        r.command_start = 1'b1;
        if ((b >= 8'h80 && b <= 8'hBF) || (b >= 8'hE0 && b <= 8'hEF)) begin
          remain = 32'd2;
          ph = PH_FIXED;
        end else if (b >= 8'hC0 && b <= 8'hDF) begin
          remain = 32'd1;
          ph = PH_FIXED;
        end else if (b == StatusSysexStart || b == StatusSysexEnd) begin
          ph = PH_SYSEX;
        end else if (b == StatusMeta) begin
          acc = '0;
          acc_len = '0;
          ph = PH_META_LEN;
        end else begin
          err = ERR_BAD_STATUS;
        end
      end
      PH_FIXED, PH_META_BODY: begin
        has_byte = 1'b1;
        if (remain != 0) remain--;
        if (remain == 0) begin
          ends = 1'b1;
          ph = PH_DELTA;
        end
      end
      PH_SYSEX: begin
        has_byte = 1'b1;
        if (b == StatusSysexStart || b == StatusSysexEnd) begin
          ends = 1'b1;
          r.trim_byte = (b == StatusSysexStart);
          ph = PH_DELTA;
        end
      end
      PH_META_LEN: begin
        has_byte = 1'b1;
        vl = take_varlen(b);
        if (vl < 0) begin
          err = ERR_VARLEN;
        end else if (vl > 0) begin
          if (acc > MetaLenBase - 32'(acc_len)) begin
            err = ERR_META_LONG;
          end else if (acc == 0) begin
            ends = 1'b1;
            ph = PH_DELTA;
          end else begin
            remain = acc;
            ph = PH_META_BODY;
          end
          acc = '0;
          acc_len = '0;
        end
      end
      default: begin
        ph = PH_SKIP;
        return;
      end
    endcase
    if (err == ERR_NONE && is_last && !(has_byte && ends)) err = ERR_TRUNCATED;
    r.event_time = cur_time;
    emit = has_byte || (err != ERR_NONE);
    if (err != ERR_NONE) begin
      ph = PH_SKIP;
      r.command_start = 1'b0;
      r.trim_byte = 1'b0;
      r.error_code = err;
      return;
    end
    r.command_end = ends;
    if (is_last) ph = PH_SKIP;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    result_t pred;
    bit      emit;
    if (rst) begin
      delay = '0;
      ph = PH_SKIP;
      remain = '0;
      acc = '0;
      acc_len = '0;
      cur_time = '0;
      expected_bytes.delete();
    end else begin
      if (cfg_wr_en) delay = cfg_wr_data;
      if (out_valid && out_ready) begin
        timed_bytes++;
        if (error_code != 3'(ERR_NONE)) error_reports++;
        if (expected_bytes.size() == 0) begin
          $error("output transaction with nothing expected: byte 0x%0h time 0x%0h",
                 midi_byte, event_time);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          check_field("midi_byte", 32'(want.midi_byte), 32'(midi_byte));
          check_field("event_time", want.event_time, event_time);
          check_field("command_start", 32'(want.command_start), 32'(command_start));
          check_field("command_end", 32'(want.command_end), 32'(command_end));
          check_field("trim_byte", 32'(want.trim_byte), 32'(trim_byte));
          check_field("error_code", 32'(want.error_code), 32'(error_code));
        end
      end
      if (in_valid && in_ready) begin
        parse_byte(data_byte, first_of_list, last_of_list, packet_time, z_flag, emit, pred);
        if (emit) expected_bytes.push_back(pred);
      end
    end
    pending <= expected_bytes.size();
  end

endmodule

// ----- tb/sv/rtp_midi_command_list_parser_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtp_midi_command_list_parser_tb
// Drives RTP MIDI command lists into the parser: a short directed set of
// edge cases, then random packets (mostly well formed, some truncated,
// malformed, abandoned or pure noise) under several playout delays, with
// random gaps and stalls on both channels. A separate checker predicts and
// compares the timed output bytes.
// ----------------------------------------------------------------------------
module rtp_midi_command_list_parser_tb;
  import rmcl_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int NUM_ITEMS    = 1150;
  localparam int PHASE_ITEMS  = 200;
  localparam int HOLD_AT      = 600;
  localparam int LONG_HOLD    = 150;
  localparam int SETTLE       = 6;
  localparam int END_CYCLES   = 10;
  localparam int WDOG_LIMIT   = 3000;

  typedef struct packed {
    logic [7:0]  data;
    logic        is_first;
    logic        is_last;
    logic [31:0] ptime;
    logic        zf;
  } byte_item_t;

  typedef enum {CMD_THREE, CMD_TWO, CMD_SYSEX, CMD_META, CMD_BAD} cmd_kind_t;
  typedef enum {PKT_GOOD, PKT_TRUNC, PKT_BAD_STATUS, PKT_OVERFLOW, PKT_META_LONG,
                PKT_ABANDON, PKT_NOISE} pkt_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        first_of_list = 1'b0;
  logic        last_of_list = 1'b0;
  logic [31:0] packet_time = '0;
  logic        z_flag = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  midi_byte;
  logic [31:0] event_time;
  logic        command_start;
  logic        command_end;
  logic        trim_byte;
  logic [2:0]  error_code;

  int mismatches;
  int pending;
  int timed_bytes;
  int error_reports;
  int items_sent = 0;
  int packets_sent = 0;
  int delay_settings = 0;
  int idle_cycles = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  bit hold_req = 1'b0;

  byte_item_t pkt[$];

  always #HALF_PERIOD clk = ~clk;

  rtp_midi_command_list_parser dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .first_of_list(first_of_list), .last_of_list(last_of_list),
    .packet_time(packet_time), .z_flag(z_flag),
    .out_valid(out_valid), .out_ready(out_ready),
    .midi_byte(midi_byte), .event_time(event_time),
    .command_start(command_start), .command_end(command_end),
    .trim_byte(trim_byte), .error_code(error_code)
  );

  rtp_midi_parse_checker u_check (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .first_of_list(first_of_list), .last_of_list(last_of_list),
    .packet_time(packet_time), .z_flag(z_flag),
    .out_valid(out_valid), .out_ready(out_ready),
    .midi_byte(midi_byte), .event_time(event_time),
    .command_start(command_start), .command_end(command_end),
    .trim_byte(trim_byte), .error_code(error_code),
    .mismatches(mismatches), .pending(pending),
    .timed_bytes(timed_bytes), .error_reports(error_reports)
  );

  // ---- packet construction ----
  function automatic void push_item(input logic [7:0] d, input logic f, input logic l);
    byte_item_t it;
    it.data = d;
    it.is_first = f;
    it.is_last = l;
    it.ptime = $urandom;
    it.zf = 1'($urandom_range(0, 1));
    pkt.push_back(it);
  endfunction

  function automatic void push_byte(input logic [7:0] d);
    push_item(d, 1'b0, 1'b0);
  endfunction

  // MSB-first varlen, padded with leading zero groups up to minlen bytes
  function automatic void push_varlen(input logic [31:0] v, input int minlen);
    int n;
    logic [7:0] b;
    n = 1;
    while (n < 5 && (v >> (7 * n)) != 0) n++;
    if (n < minlen) n = minlen;
    for (int i = n - 1; i >= 0; i--) begin
      b = (i >= 5) ? 8'h00 : 8'((v >> (7 * i)) & 32'h7F);
      push_byte((i != 0) ? (b | 8'h80) : b);
    end
  endfunction

  function automatic int pad_len();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(2, 9) : 1;
  endfunction

  function automatic void push_delta();
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0: v = '0;
      1: v = $urandom_range(0, 127);
      2: v = $urandom_range(128, 16383);
      3: v = $urandom;
      default: v = 32'hFFFF_FFFF;
    endcase
    push_varlen(v, pad_len());
  endfunction

  // accumulator passes the shift limit after four bytes past the optional leading zero group
  function automatic void push_overflow();
    if ($urandom_range(0, 1)) push_byte(8'h80);
    push_byte(8'($urandom_range(8'h90, 8'hFF)));
    repeat (3) push_byte(8'($urandom_range(8'h80, 8'hFF)));
    push_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic logic [7:0] bad_status();
    case ($urandom_range(0, 2))
      0: return 8'($urandom_range(8'h00, 8'h7F));
      1: return 8'($urandom_range(8'hF1, 8'hF6));
      default: return 8'($urandom_range(8'hF8, 8'hFE));
    endcase
  endfunction

  function automatic void push_command(input cmd_kind_t kind);
    int n;
    logic [7:0] b;
    case (kind)
      CMD_THREE: begin
        push_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                       : 8'($urandom_range(8'hE0, 8'hEF)));
        repeat (2) push_byte(8'($urandom_range(0, 255)));
      end
      CMD_TWO: begin
        push_byte(8'($urandom_range(8'hC0, 8'hDF)));
        push_byte(8'($urandom_range(0, 255)));
      end
      CMD_SYSEX: begin
        push_byte($urandom_range(0, 1) ? StatusSysexStart : StatusSysexEnd);
        n = $urandom_range(0, 6);
        repeat (n) begin
          b = 8'($urandom_range(0, 255));
          if (b == StatusSysexStart || b == StatusSysexEnd) b = b & 8'h7F;
          push_byte(b);
        end
        push_byte($urandom_range(0, 1) ? StatusSysexStart : StatusSysexEnd);
      end
      CMD_META: begin
        push_byte(StatusMeta);
        n = $urandom_range(0, 5);
        push_varlen(32'(n), pad_len());
        repeat (n) push_byte(8'($urandom_range(0, 255)));
      end
      default: push_byte(bad_status());
    endcase
  endfunction

  function automatic void seal_packet(input logic [31:0] ptime, input logic zf,
                                      input bit with_last);
    byte_item_t it;
    it = pkt[0];
    it.is_first = 1'b1;
    it.ptime = ptime;
    it.zf = zf;
    pkt[0] = it;
    if (with_last) begin
      it = pkt[pkt.size() - 1];
      it.is_last = 1'b1;
      pkt[pkt.size() - 1] = it;
    end
  endfunction

  function automatic pkt_mode_t pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return PKT_GOOD;
    if (r < 76) return PKT_TRUNC;
    if (r < 81) return PKT_BAD_STATUS;
    if (r < 86) return PKT_OVERFLOW;
    if (r < 90) return PKT_META_LONG;
    if (r < 95) return PKT_ABANDON;
    return PKT_NOISE;
  endfunction

  function automatic void build_packet(input pkt_mode_t mode);
    logic        zf;
    logic [31:0] ptime;
    logic [31:0] len;
    int          ncmd;
    int          nlen;
    int          cut;
    pkt.delete();
    if (mode == PKT_NOISE) begin
      repeat ($urandom_range(1, 6))
        push_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                  $urandom_range(0, 3) == 0);
      return;
    end
    zf = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0: ptime = '0;
      1: ptime = 32'hFFFF_FFFF;
      default: ptime = $urandom;
    endcase
    ncmd = (mode == PKT_GOOD) ? $urandom_range(1, 5) : $urandom_range(0, 3);
    for (int c = 0; c < ncmd; c++) begin
      if (c > 0 || zf) push_delta();
      push_command(cmd_kind_t'($urandom_range(0, 3)));
    end
    case (mode)
      PKT_BAD_STATUS: begin
        if (ncmd > 0 || zf) push_delta();
        push_command(CMD_BAD);
        repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)));
      end
      PKT_OVERFLOW: begin
        if ((ncmd > 0 || zf) && $urandom_range(0, 1)) begin
          push_overflow();
        end else begin
          if (ncmd > 0 || zf) push_delta();
          push_byte(StatusMeta);
          push_overflow();
        end
      end
      PKT_META_LONG: begin
        if (ncmd > 0 || zf) push_delta();
        push_byte(StatusMeta);
        nlen = $urandom_range(5, 9);
        len = MetaLenBase - 32'((nlen > 7) ? 7 : nlen) + 32'($urandom_range(0, 1));
        push_varlen(len, nlen);
        repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    if (pkt.size() == 0) push_command(CMD_TWO);
    if (mode == PKT_TRUNC || mode == PKT_ABANDON) begin
      cut = $urandom_range(1, pkt.size());
      while (pkt.size() > cut) void'(pkt.pop_back());
    end
    seal_packet(ptime, zf, mode != PKT_ABANDON);
  endfunction

  // ---- driving ----
  task automatic send_item(input byte_item_t it);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    data_byte = it.data;
    first_of_list = it.is_first;
    last_of_list = it.is_last;
    packet_time = it.ptime;
    z_flag = it.zf;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_item(pkt[i]);
    packets_sent++;
  endtask

  task automatic wait_idle(input int settle);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_delay(input logic [31:0] v);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    delay_settings++;
  endtask

  function automatic logic [31:0] next_delay(input int k);
    case (k % 5)
      0: return '0;
      1: return $urandom;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  // ---- receiver ----
  initial begin : receiver
    int stall;
    int served;
    served = 0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = rx_burst ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
      served++;
      if (served % 16 == 0) rx_burst = ($urandom_range(0, 3) == 0);
    end
  end

  // ---- watchdog ----
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", WDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---- stimulus ----
  initial begin : stimulus
    int  k;
    int  cfg_mark;
    bit  hold_done;
    k = 0;
    hold_done = 1'b0;
    repeat (3) @(negedge clk);
    rst = 1'b0;
    write_delay(32'hFFFF_FFFF);

    // max delta on max timestamp and delay: time wraps
    pkt.delete();
    push_varlen(32'hFFFF_FFFF, 1);
    push_byte(8'hE0);
    push_byte(8'h00);
    push_byte(8'h7F);
    seal_packet(32'hFFFF_FFFF, 1'b1, 1'b1);
    send_packet();
    // empty meta event, then SysEx segment closed by F0 (trimmed)
    pkt.delete();
    push_byte(StatusMeta);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(StatusSysexStart);
    push_byte(8'h7F);
    push_byte(StatusSysexStart);
    seal_packet(32'h0, 1'b0, 1'b1);
    send_packet();
    // bad status, rest of packet skipped
    pkt.delete();
    push_byte(8'hF5);
    push_byte(8'h3C);
    seal_packet(32'h8000_0000, 1'b0, 1'b1);
    send_packet();
    // two-byte command cut short
    pkt.delete();
    push_byte(8'hC5);
    seal_packet(32'h1234_5678, 1'b0, 1'b1);
    send_packet();
    // meta length above the limit
    pkt.delete();
    push_byte(StatusMeta);
    push_varlen(32'hFFFF_FFFF, 1);
    seal_packet(32'h0000_0001, 1'b0, 1'b1);
    send_packet();
    // delta overflow
    pkt.delete();
    push_byte(8'h9F);
    repeat (3) push_byte(8'hFF);
    push_byte(8'h00);
    seal_packet(32'h7FFF_FFFF, 1'b1, 1'b1);
    send_packet();

    cfg_mark = items_sent;
    while (items_sent < NUM_ITEMS) begin
      if (items_sent >= cfg_mark) begin
        wait_idle(SETTLE);
        write_delay(next_delay(k));
        k++;
        cfg_mark += PHASE_ITEMS;
      end
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      tx_burst = ($urandom_range(0, 3) == 0);
      build_packet(pick_mode());
      send_packet();
    end

    wait_idle(END_CYCLES);
    $display("Sent %0d bytes in %0d packets under %0d playout delay settings.",
             items_sent, packets_sent, delay_settings);
    $display("Checked %0d output bytes, %0d of them error reports.",
             timed_bytes, error_reports);
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
